### rtl/mi_pkg.sv
package mi_pkg;

	// word width of operand, modulus and inverse (8..64)
	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);
	localparam int S_TDATA_W = ((2 * WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_W = ((WIDTH + 7) / 8) * 8;

	typedef logic [WIDTH-1:0] word_t;

	typedef enum logic {
		DIV_SRC_INPUT,
		DIV_SRC_LOOP
	} div_src_t;

	typedef struct packed {
		logic     load;
		logic     div_load;
		div_src_t div_src;
		logic     div_step;
		logic     seed;
		logic     mul;
		logic     upd;
		logic     fin;
	} mi_cmd_t;

	typedef struct packed {
		logic m_zero;
		logic r1_zero;
		logic div_last;
	} mi_sts_t;

endpackage

### rtl/mi_datapath.sv
module mi_datapath import mi_pkg::*; (
	input  logic                 clk,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  mi_cmd_t              cmd,
	output mi_sts_t              sts,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [0:0]           m_tuser
);

	word_t a_q, m_q;
	word_t r0_q, r1_q, u0_q, u1_q;
	word_t dn_q, rm_q, dd_q;
	word_t prod_q, inv_q;
	logic  par_q, noinv_q;
	logic [CNT_W-1:0] cnt_q;

	logic [WIDTH:0]     sh, diff;
	logic               ge;
	logic [2*WIDTH-1:0] mul_full;
	word_t              u0_red, inv_d;

	// one restoring-division bit per step; dn_q ends up holding the quotient
	assign sh   = {rm_q, dn_q[WIDTH-1]};
	assign diff = sh - {1'b0, dd_q};
	assign ge   = !diff[WIDTH];

	assign mul_full = dn_q * u1_q;

	// |u0| never exceeds the modulus, so the reduction is one compare
	assign u0_red = (u0_q == m_q) ? '0 : u0_q;
	assign inv_d  = (par_q || u0_red == '0) ? u0_red : m_q - u0_red;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= s_tdata[WIDTH-1:0];
			m_q <= s_tdata[2*WIDTH-1:WIDTH];
		end
		if (cmd.div_load) begin
			rm_q  <= '0;
			cnt_q <= '0;
			if (cmd.div_src == DIV_SRC_INPUT) begin
				dn_q <= a_q;
				dd_q <= m_q;
			end else begin
				dn_q <= r0_q;
				dd_q <= r1_q;
			end
		end else if (cmd.div_step) begin
			rm_q  <= ge ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
			dn_q  <= {dn_q[WIDTH-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.seed) begin
			r0_q  <= m_q;
			r1_q  <= rm_q;
			u0_q  <= '0;
			u1_q  <= word_t'(1);
			par_q <= 1'b0;
		end
		if (cmd.mul)
			prod_q <= mul_full[WIDTH-1:0];
		if (cmd.upd) begin
			r0_q  <= r1_q;
			r1_q  <= rm_q;
			u0_q  <= u1_q;
			u1_q  <= u0_q + prod_q;
			par_q <= !par_q;
		end
		if (cmd.fin) begin
			if (m_q == '0 || r0_q != word_t'(1)) begin
				inv_q   <= '0;
				noinv_q <= 1'b1;
			end else begin
				inv_q   <= inv_d;
				noinv_q <= 1'b0;
			end
		end
	end

	assign sts.m_zero   = (m_q == '0);
	assign sts.r1_zero  = (r1_q == '0);
	assign sts.div_last = (cnt_q == CNT_W'(WIDTH - 1));

	assign m_tdata = M_TDATA_W'(inv_q);
	assign m_tuser = noinv_q;

endmodule

### rtl/mi_ctrl.sv
module mi_ctrl import mi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  mi_sts_t sts,
	output mi_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRE,
		ST_DIV_A,
		ST_SEED,
		ST_CHECK,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd          = '0;
		cmd.div_src  = DIV_SRC_INPUT;
		case (state_q)
			ST_IDLE:  cmd.load = s_tvalid;
			ST_PRE:   cmd.div_load = 1'b1;
			ST_DIV_A: cmd.div_step = 1'b1;
			ST_SEED:  cmd.seed = 1'b1;
			ST_CHECK: begin
				cmd.div_load = !sts.r1_zero;
				cmd.div_src  = DIV_SRC_LOOP;
			end
			ST_DIV:   cmd.div_step = 1'b1;
			ST_MUL:   cmd.mul = 1'b1;
			ST_UPD:   cmd.upd = 1'b1;
			ST_FIN:   cmd.fin = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (s_tvalid) state_q <= ST_PRE;
				ST_PRE:   state_q <= sts.m_zero ? ST_FIN : ST_DIV_A;
				ST_DIV_A: if (sts.div_last) state_q <= ST_SEED;
				ST_SEED:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= sts.r1_zero ? ST_FIN : ST_DIV;
				ST_DIV:   if (sts.div_last) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_UPD;
				ST_UPD:   state_q <= ST_CHECK;
				ST_FIN:   if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/modular_inverse_top.sv
// channel | dir | signals                     | contents (lowest bit up)
// s       | in  | s_tvalid s_tready s_tdata   | operand, modulus
// m       | out | m_tvalid m_tready m_tdata   | inverse ; m_tuser: no_inverse
//
// One item at a time: the set-up and each Euclid step run a division through
// the one-bit-a-cycle restoring divider.
// The result waits in the output register; a stalled m side holds the
// block in its final state until the register is free.
// arst_n clears the controller and the output valid.
module modular_inverse_top import mi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // operand, modulus
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // inverse
	output logic [0:0]           m_tuser   // no_inverse
);

	mi_cmd_t cmd;
	mi_sts_t sts;

	mi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mi_datapath u_dp (
		.clk     (clk),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

### rtl/mi_checker.sv
module mi_checker import mi_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [0:0]           m_tuser
);

	// a result waiting on the m side stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// a failed inversion always reports zero
	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[WIDTH-1:0] == '0)
		else $error("no_inverse with non-zero inverse");

	// one item in flight: busy right after an accepted transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction accepted while busy");

	// no result can come out the cycle after an item is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

endmodule

bind modular_inverse_top mi_checker u_mi_checker (.*);
